### rtl/srfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfi_pkg
// Types, operation codes and register constants shared by the short range
// force and integrate block.
// ----------------------------------------------------------------------------
package srfi_pkg;

  typedef struct packed {
    logic [30:0]        particle_x;
    logic [30:0]        particle_y;
    logic signed [31:0] particle_vx;
    logic signed [31:0] particle_vy;
    logic [30:0]        neighbor_x;
    logic [30:0]        neighbor_y;
    logic               neighbor_present;
    logic               last_neighbor;
  } in_item_t;

  typedef struct packed {
    logic [30:0]        new_x;
    logic [30:0]        new_y;
    logic signed [31:0] new_vx;
    logic signed [31:0] new_vy;
  } out_item_t;

  localparam int OP_W = 5;

  localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 5'd1;
  localparam logic [OP_W-1:0] OP_R2X     = 5'd2;
  localparam logic [OP_W-1:0] OP_R2Y     = 5'd3;
  localparam logic [OP_W-1:0] OP_CUT2    = 5'd4;
  localparam logic [OP_W-1:0] OP_LIM2    = 5'd5;
  localparam logic [OP_W-1:0] OP_LIM     = 5'd6;
  localparam logic [OP_W-1:0] OP_CLAMP   = 5'd7;
  localparam logic [OP_W-1:0] OP_SQRT    = 5'd8;
  localparam logic [OP_W-1:0] OP_RMASS   = 5'd9;
  localparam logic [OP_W-1:0] OP_NUMX    = 5'd10;
  localparam logic [OP_W-1:0] OP_NUMY    = 5'd11;
  localparam logic [OP_W-1:0] OP_D0      = 5'd12;
  localparam logic [OP_W-1:0] OP_D1      = 5'd13;
  localparam logic [OP_W-1:0] OP_D2      = 5'd14;
  localparam logic [OP_W-1:0] OP_D3      = 5'd15;
  localparam logic [OP_W-1:0] OP_D4      = 5'd16;
  localparam logic [OP_W-1:0] OP_DIVINIT = 5'd17;
  localparam logic [OP_W-1:0] OP_DIV     = 5'd18;
  localparam logic [OP_W-1:0] OP_ACC     = 5'd19;
  localparam logic [OP_W-1:0] OP_VA0     = 5'd20;
  localparam logic [OP_W-1:0] OP_VA1     = 5'd21;
  localparam logic [OP_W-1:0] OP_VA2     = 5'd22;
  localparam logic [OP_W-1:0] OP_VEL     = 5'd23;
  localparam logic [OP_W-1:0] OP_XA0     = 5'd24;
  localparam logic [OP_W-1:0] OP_XA1     = 5'd25;
  localparam logic [OP_W-1:0] OP_XA2     = 5'd26;
  localparam logic [OP_W-1:0] OP_POS     = 5'd27;
  localparam logic [OP_W-1:0] OP_WALL    = 5'd28;
  localparam logic [OP_W-1:0] OP_EMIT    = 5'd29;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            axis;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_of_range;
    logic den_zero;
  } ctl_status_t;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 3'd4;

  localparam logic [30:0] RST_CUTOFF = 31'd655;
  localparam logic [30:0] RST_MINR   = 31'd66;
  localparam logic [30:0] RST_MASS   = 31'd655;
  localparam logic [31:0] RST_DT     = 32'd2147484;
  localparam logic [30:0] RST_SIZE   = 31'd65536;

  localparam int CNT_W      = 6;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 63;

endpackage

### rtl/srfi_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfi_ctrl
// Sequencer that steps the datapath through force accumulation, integration
// and result delivery for each accepted transaction.
// ----------------------------------------------------------------------------
module srfi_ctrl
  import srfi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        present,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  input  ctl_status_t status,
  output ctl_cmd_t    cmd
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_R2X     = 5'd1;
  localparam logic [4:0] ST_R2Y     = 5'd2;
  localparam logic [4:0] ST_CUT2    = 5'd3;
  localparam logic [4:0] ST_LIM2    = 5'd4;
  localparam logic [4:0] ST_LIM     = 5'd5;
  localparam logic [4:0] ST_CLAMP   = 5'd6;
  localparam logic [4:0] ST_SQRT    = 5'd7;
  localparam logic [4:0] ST_RMASS   = 5'd8;
  localparam logic [4:0] ST_NUMX    = 5'd9;
  localparam logic [4:0] ST_NUMY    = 5'd10;
  localparam logic [4:0] ST_D0      = 5'd11;
  localparam logic [4:0] ST_D1      = 5'd12;
  localparam logic [4:0] ST_D2      = 5'd13;
  localparam logic [4:0] ST_D3      = 5'd14;
  localparam logic [4:0] ST_D4      = 5'd15;
  localparam logic [4:0] ST_DIVINIT = 5'd16;
  localparam logic [4:0] ST_DIV     = 5'd17;
  localparam logic [4:0] ST_ACC     = 5'd18;
  localparam logic [4:0] ST_VA0     = 5'd19;
  localparam logic [4:0] ST_VA1     = 5'd20;
  localparam logic [4:0] ST_VA2     = 5'd21;
  localparam logic [4:0] ST_VEL     = 5'd22;
  localparam logic [4:0] ST_XA0     = 5'd23;
  localparam logic [4:0] ST_XA1     = 5'd24;
  localparam logic [4:0] ST_XA2     = 5'd25;
  localparam logic [4:0] ST_POS     = 5'd26;
  localparam logic [4:0] ST_WALL    = 5'd27;
  localparam logic [4:0] ST_EMIT    = 5'd28;

  logic [4:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             axis, axis_next;
  logic             last_q, last_next;
  logic             out_valid_next;
  logic [4:0]       after_force;

  assign after_force = last_q ? ST_VA0 : ST_IDLE;

  always_comb begin
    state_next     = state;
    count_next     = count;
    axis_next      = axis;
    last_next      = last_q;
    in_ready       = 1'b0;
    cmd.op         = OP_NOP;
    cmd.axis       = axis;
    out_valid_next = out_valid & ~out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          last_next = last;
          axis_next = 1'b0;
          if (present) begin
            state_next = ST_R2X;
          end else if (last) begin
            state_next = ST_VA0;
          end
        end
      end
      ST_R2X: begin
        cmd.op     = OP_R2X;
        state_next = ST_R2Y;
      end
      ST_R2Y: begin
        cmd.op     = OP_R2Y;
        state_next = ST_CUT2;
      end
      ST_CUT2: begin
        cmd.op     = OP_CUT2;
        state_next = ST_LIM2;
      end
      ST_LIM2: begin
        cmd.op     = OP_LIM2;
        state_next = ST_LIM;
      end
      ST_LIM: begin
        cmd.op     = OP_LIM;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (status.out_of_range) begin
          state_next = after_force;
        end else begin
          cmd.op     = OP_CLAMP;
          count_next = '0;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (count == CNT_W'(SQRT_STEPS - 1)) begin
          count_next = '0;
          state_next = ST_RMASS;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_RMASS: begin
        cmd.op     = OP_RMASS;
        state_next = ST_NUMX;
      end
      ST_NUMX: begin
        cmd.op     = OP_NUMX;
        state_next = ST_NUMY;
      end
      ST_NUMY: begin
        cmd.op     = OP_NUMY;
        state_next = ST_D0;
      end
      ST_D0: begin
        cmd.op     = OP_D0;
        state_next = ST_D1;
      end
      ST_D1: begin
        cmd.op     = OP_D1;
        state_next = ST_D2;
      end
      ST_D2: begin
        cmd.op     = OP_D2;
        state_next = ST_D3;
      end
      ST_D3: begin
        cmd.op     = OP_D3;
        state_next = ST_D4;
      end
      ST_D4: begin
        cmd.op     = OP_D4;
        state_next = ST_DIVINIT;
      end
      ST_DIVINIT: begin
        if (status.den_zero) begin
          state_next = after_force;
        end else begin
          cmd.op     = OP_DIVINIT;
          count_next = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          count_next = '0;
          state_next = ST_ACC;
        end else begin
          count_next = count + 1'b1;
        end
      end
      ST_ACC: begin
        cmd.op     = OP_ACC;
        state_next = after_force;
      end
      ST_VA0: begin
        cmd.op     = OP_VA0;
        state_next = ST_VA1;
      end
      ST_VA1: begin
        cmd.op     = OP_VA1;
        state_next = ST_VA2;
      end
      ST_VA2: begin
        cmd.op     = OP_VA2;
        state_next = ST_VEL;
      end
      ST_VEL: begin
        cmd.op     = OP_VEL;
        state_next = ST_XA0;
      end
      ST_XA0: begin
        cmd.op     = OP_XA0;
        state_next = ST_XA1;
      end
      ST_XA1: begin
        cmd.op     = OP_XA1;
        state_next = ST_XA2;
      end
      ST_XA2: begin
        cmd.op     = OP_XA2;
        state_next = ST_POS;
      end
      ST_POS: begin
        cmd.op     = OP_POS;
        state_next = ST_WALL;
      end
      ST_WALL: begin
        cmd.op = OP_WALL;
        if (axis) begin
          state_next = ST_EMIT;
        end else begin
          axis_next  = 1'b1;
          state_next = ST_VA0;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      axis      <= 1'b0;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      axis      <= axis_next;
      last_q    <= last_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/srfi_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfi_datapath
// Configuration registers, accumulators, a shared 32x32 multiplier, the
// square root and divider iterations, and the integration and wall logic.
// ----------------------------------------------------------------------------
module srfi_datapath
  import srfi_pkg::*;
#(
  parameter int WORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_cmd_t             cmd,
  input  in_item_t             in_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output ctl_status_t          status,
  output out_item_t            out_data
);

  localparam logic signed [65:0] VMAX = (66'sd1 <<< (WORD_WIDTH - 1)) - 66'sd1;
  localparam logic signed [65:0] VMIN = -VMAX - 66'sd1;
  localparam logic signed [63:0] INT_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] INT_MIN = {1'b1, {63{1'b0}}};

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] t);
    logic signed [64:0] s;
    s = {a[63], a} + {t[63], t};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? INT_MIN : INT_MAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  logic [30:0] cutoff, min_r, mass, size;
  logic [31:0] dt;

  logic [30:0]        px, py;
  logic signed [31:0] v0x, v0y, dx, dy;
  logic signed [32:0] num;
  logic [31:0]        adx, ady;
  logic [32:0]        anum;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [63:0]  r2, r2c, sv, res, bitv, root_sum;
  logic [61:0]  cut2, lim, den1, nmx, nmy;
  logic [123:0] den;
  logic [124:0] remx, remy, remx2, remy2;
  logic [62:0]  qx, qy;
  logic         satx, saty;
  logic [63:0]  qfx, qfy;

  logic signed [63:0] accx, accy, acc_sel, vel_sel;
  logic signed [63:0] vel [2];
  logic [30:0]        posr [2];
  logic [95:0]        sp;
  logic signed [65:0] xraw;
  logic [63:0]        acc_mag, vel_mag;

  logic signed [65:0] vsum, vsat, xsize, xr, xc, vr;
  logic               wall_lo, wall_hi;

  assign adx     = dx[31] ? 32'(-dx) : 32'(dx);
  assign ady     = dy[31] ? 32'(-dy) : 32'(dy);
  assign anum    = num[32] ? 33'(-num) : 33'(num);
  assign acc_sel = cmd.axis ? accy : accx;
  assign vel_sel = cmd.axis ? vel[1] : vel[0];
  assign acc_mag = mag64(acc_sel);
  assign vel_mag = mag64(vel_sel);

  assign r2c      = (r2 < {2'b0, lim}) ? {2'b0, lim} : r2;
  assign root_sum = res + bitv;
  assign remx2    = {remx[123:0], 1'b0};
  assign remy2    = {remy[123:0], 1'b0};
  assign qfx      = satx ? {1'b0, {63{1'b1}}} : {1'b0, qx};
  assign qfy      = saty ? {1'b0, {63{1'b1}}} : {1'b0, qy};

  assign status.out_of_range = r2 > {2'b0, cut2};
  assign status.den_zero     = (den == '0);

  always_comb begin
    vsum = 66'(cmd.axis ? v0y : v0x);
    if (acc_sel[63]) begin
      vsum = vsum - $signed({18'b0, sp[95:48]});
    end else begin
      vsum = vsum + $signed({18'b0, sp[95:48]});
    end
    if (vsum > VMAX) begin
      vsat = VMAX;
    end else if (vsum < VMIN) begin
      vsat = VMIN;
    end else begin
      vsat = vsum;
    end
  end

  always_comb begin
    xsize   = $signed({35'b0, size});
    wall_lo = xraw < 66'sd0;
    wall_hi = xraw > xsize;
    vr      = 66'(vel_sel);
    xr      = xraw;
    if (wall_lo) begin
      xr = -xraw;
    end else if (wall_hi) begin
      xr = (xsize <<< 1) - xraw;
    end
    if (wall_lo || wall_hi) begin
      vr = (66'(vel_sel) == VMIN) ? VMAX : -66'(vel_sel);
    end
    if (xr < 66'sd0) begin
      xc = '0;
    end else if (xr > xsize) begin
      xc = xsize;
    end else begin
      xc = xr;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_R2X: begin
        mul_a = adx;
        mul_b = adx;
      end
      OP_R2Y: begin
        mul_a = ady;
        mul_b = ady;
      end
      OP_CUT2: begin
        mul_a = {1'b0, cutoff};
        mul_b = {1'b0, cutoff};
      end
      OP_LIM2: begin
        mul_a = {1'b0, min_r};
        mul_b = {1'b0, min_r};
      end
      OP_RMASS: begin
        mul_a = {1'b0, res[30:0]};
        mul_b = {1'b0, mass};
      end
      OP_NUMX: begin
        mul_a = adx;
        mul_b = anum[31:0];
      end
      OP_NUMY: begin
        mul_a = ady;
        mul_b = anum[31:0];
      end
      OP_D0: begin
        mul_a = {1'b0, den1[30:0]};
        mul_b = {1'b0, r2[30:0]};
      end
      OP_D1: begin
        mul_a = {1'b0, den1[30:0]};
        mul_b = {1'b0, r2[61:31]};
      end
      OP_D2: begin
        mul_a = {1'b0, den1[61:31]};
        mul_b = {1'b0, r2[30:0]};
      end
      OP_D3: begin
        mul_a = {1'b0, den1[61:31]};
        mul_b = {1'b0, r2[61:31]};
      end
      OP_VA0: begin
        mul_a = acc_mag[31:0];
        mul_b = dt;
      end
      OP_VA1: begin
        mul_a = acc_mag[63:32];
        mul_b = dt;
      end
      OP_XA0: begin
        mul_a = vel_mag[31:0];
        mul_b = dt;
      end
      OP_XA1: begin
        mul_a = vel_mag[63:32];
        mul_b = dt;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= RST_CUTOFF;
      min_r  <= RST_MINR;
      mass   <= RST_MASS;
      dt     <= RST_DT;
      size   <= RST_SIZE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CUTOFF: cutoff <= cfg_data[30:0];
        CFG_MINR:   min_r  <= cfg_data[30:0];
        CFG_MASS:   mass   <= cfg_data[30:0];
        CFG_DT:     dt     <= cfg_data;
        CFG_SIZE:   size   <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accx <= '0;
      accy <= '0;
    end else if (cmd.op == OP_ACC) begin
      accx <= sat_add(accx, (dx[31] ^ num[32]) ? 64'(-qfx) : qfx);
      accy <= sat_add(accy, (dy[31] ^ num[32]) ? 64'(-qfy) : qfy);
    end else if (cmd.op == OP_EMIT) begin
      accx <= '0;
      accy <= '0;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (cmd.op)
      OP_LOAD: begin
        px  <= in_data.particle_x;
        py  <= in_data.particle_y;
        v0x <= in_data.particle_vx;
        v0y <= in_data.particle_vy;
        dx  <= $signed({1'b0, in_data.neighbor_x}) - $signed({1'b0, in_data.particle_x});
        dy  <= $signed({1'b0, in_data.neighbor_y}) - $signed({1'b0, in_data.particle_y});
      end
      OP_R2Y:  r2   <= prod;
      OP_CUT2: r2   <= r2 + prod;
      OP_LIM2: cut2 <= prod[61:0];
      OP_LIM:  lim  <= prod[61:0];
      OP_CLAMP: begin
        r2   <= r2c;
        sv   <= r2c;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT: begin
        if (sv >= root_sum) begin
          sv  <= sv - root_sum;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      OP_RMASS: num  <= $signed({2'b0, res[30:0]}) - $signed({2'b0, cutoff});
      OP_NUMX:  den1 <= prod[61:0];
      OP_NUMY:  nmx  <= prod[61:0];
      OP_D0:    nmy  <= prod[61:0];
      OP_D1:    den  <= {62'b0, prod[61:0]};
      OP_D2:    den  <= den + ({62'b0, prod[61:0]} << 31);
      OP_D3:    den  <= den + ({62'b0, prod[61:0]} << 31);
      OP_D4:    den  <= den + ({62'b0, prod[61:0]} << 62);
      OP_DIVINIT: begin
        satx <= {61'b0, nmx, 1'b0} >= den;
        saty <= {61'b0, nmy, 1'b0} >= den;
        remx <= {62'b0, nmx, 1'b0};
        remy <= {62'b0, nmy, 1'b0};
        qx   <= '0;
        qy   <= '0;
      end
      OP_DIV: begin
        if (remx2 >= {1'b0, den}) begin
          remx <= remx2 - {1'b0, den};
          qx   <= {qx[61:0], 1'b1};
        end else begin
          remx <= remx2;
          qx   <= {qx[61:0], 1'b0};
        end
        if (remy2 >= {1'b0, den}) begin
          remy <= remy2 - {1'b0, den};
          qy   <= {qy[61:0], 1'b1};
        end else begin
          remy <= remy2;
          qy   <= {qy[61:0], 1'b0};
        end
      end
      OP_VA1, OP_XA1: sp <= {32'b0, prod};
      OP_VA2, OP_XA2: sp <= sp + {prod, 32'b0};
      OP_VEL: begin
        if (cmd.axis) begin
          vel[1] <= vsat[63:0];
        end else begin
          vel[0] <= vsat[63:0];
        end
      end
      OP_POS: begin
        if (vel_sel[63]) begin
          xraw <= $signed({35'b0, cmd.axis ? py : px}) - $signed({2'b0, sp[95:32]});
        end else begin
          xraw <= $signed({35'b0, cmd.axis ? py : px}) + $signed({2'b0, sp[95:32]});
        end
      end
      OP_WALL: begin
        if (cmd.axis) begin
          posr[1] <= xc[30:0];
          vel[1]  <= vr[63:0];
        end else begin
          posr[0] <= xc[30:0];
          vel[0]  <= vr[63:0];
        end
      end
      OP_EMIT: begin
        out_data.new_x  <= posr[0];
        out_data.new_y  <= posr[1];
        out_data.new_vx <= vel[0][31:0];
        out_data.new_vy <= vel[1][31:0];
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/short_range_force_and_integrate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// short_range_force_and_integrate
// Accumulates short range repulsive accelerations over a particle's neighbor
// transactions and integrates velocity and position on the last one.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. A transaction without a present
// neighbor and not marked last is only loaded. Work on a present neighbor is
// set by the 32-step square root and the 63-step divider that both go one
// bit per cycle, plus loading, products on the shared 32x32 multiplier and
// accumulation. The square root and divider are skipped when the neighbor
// lies beyond the cutoff, and the divider when the divisor is zero. A
// transaction marked last adds integration of each axis on the same
// multiplier and the loading of the output register, and waits while that
// register still holds a result that has not been accepted. A finished
// result waits in the output register while the next transaction is taken.
module short_range_force_and_integrate
  import srfi_pkg::*;
#(
  parameter int WORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  ctl_cmd_t    cmd;
  ctl_status_t status;

  srfi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .present   (in_data.neighbor_present),
    .last      (in_data.last_neighbor),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  srfi_datapath #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
